[hw/rtl/irn_pkg.sv]
// Shared types and constants for the nearest-neighbor image rotation core.
// No dependencies; imported by the front end, back end, top level and checker.
`timescale 1ns / 1ps

package irn_pkg;

    localparam int PIX_W   = 24;
    localparam int POS_W   = 8;
    localparam int DIM_W   = 9;
    localparam int TRIG_W  = 16;
    localparam int DELTA_W = POS_W + 2;          // signed destination offset
    localparam int PROD_W  = DELTA_W + TRIG_W;   // offset times sine/cosine
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COS    = 3'd2;
    localparam logic [2:0] REG_SIN    = 3'd3;
    localparam logic [2:0] REG_FILL   = 3'd4;

    // effective configuration seen by the datapath (dimensions already clamped)
    typedef struct packed {
        logic        [DIM_W-1:0]  width;
        logic        [DIM_W-1:0]  height;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
        logic        [PIX_W-1:0]  fill;
    } t_cfg;

    // classified item passed from the front end to the back end
    typedef struct packed {
        logic                      kind;
        logic                      ld_ok;
        logic        [POS_W-1:0]   pos_x;
        logic        [POS_W-1:0]   pos_y;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic        [PIX_W-1:0]   pixel;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             outside;
    } t_result;

endpackage

[hw/rtl/irn_fifo.sv]
// Small register-based FIFO used between the front and back ends and on the result side.
// Depends on nothing; data is a flat vector of WIDTH bits.
`timescale 1ns / 1ps

module irn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[hw/rtl/irn_front.sv]
// Front end: accepts input transactions, classifies loads and queries,
// and precomputes the offset of a query to the image center. Uses irn_pkg.
`timescale 1ns / 1ps

module irn_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_kind,
    input  logic [irn_pkg::POS_W-1:0]    i_pos_x,
    input  logic [irn_pkg::POS_W-1:0]    i_pos_y,
    input  logic [irn_pkg::PIX_W-1:0]    i_pixel_in,
    input  irn_pkg::t_cfg                i_cfg,
    input  logic                         i_mid_full,
    output logic                         o_mid_push,
    output irn_pkg::t_item               o_mid_item
);

    import irn_pkg::*;

    logic  r_vld, n_vld;
    t_item r_item, n_item;
    logic  accept;
    logic [POS_W-1:0] cx, cy;

    assign o_full     = r_vld && i_mid_full;
    assign accept     = i_push && !o_full;
    assign o_mid_push = r_vld && !i_mid_full;
    assign o_mid_item = r_item;

    // center is floor(dim / 2)
    assign cx = i_cfg.width[DIM_W-1:1];
    assign cy = i_cfg.height[DIM_W-1:1];

    always_comb begin
        n_item.kind  = i_kind;
        n_item.ld_ok = (32'(i_pos_x) < MAX_WIDTH) && (32'(i_pos_y) < MAX_HEIGHT);
        n_item.pos_x = i_pos_x;
        n_item.pos_y = i_pos_y;
        n_item.dx    = $signed({2'b00, i_pos_x}) - $signed({2'b00, cx});
        n_item.dy    = $signed({2'b00, i_pos_y}) - $signed({2'b00, cy});
        n_item.pixel = i_pixel_in;

        if (accept) begin
            n_vld = 1'b1;
        end else if (o_mid_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

[hw/rtl/irn_back.sv]
// Back end: rotation multiplies, bounds check, source store and result forming.
// Uses irn_pkg; reserves result FIFO space before taking an item.
`timescale 1ns / 1ps

module irn_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 14,
    parameter int OUT_DEPTH  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  irn_pkg::t_cfg                    i_cfg,
    input  logic                             i_mid_empty,
    input  irn_pkg::t_item                   i_mid_item,
    output logic                             o_mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                             o_res_vld,
    output irn_pkg::t_result                 o_res
);

    import irn_pkg::*;

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int SUM_W = ((FRAC_BITS > TRIG_W) ? FRAC_BITS : TRIG_W) + 12;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    // stage 1: products
    logic                      r_s1_vld;
    logic                      r_s1_kind;
    logic                      r_s1_ld_ok;
    logic        [POS_W-1:0]   r_s1_x, r_s1_y;
    logic        [PIX_W-1:0]   r_s1_pix;
    logic signed [PROD_W-1:0]  r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    // stage 2: store address
    logic                      r_s2_vld;
    logic                      r_s2_out;
    logic        [AW-1:0]      r_s2_addr;
    // stage 3: store data
    logic                      r_s3_vld;
    logic                      r_s3_out;
    logic        [PIX_W-1:0]   r_rd;

    logic [PIX_W-1:0] r_mem [DEPTH];

    logic [CNT_W:0]            reserve;
    logic                      s1_query;
    logic signed [SUM_W-1:0]   rx, ry, cx_f, cy_f, lim_x, lim_y;
    logic                      outside;
    logic        [XW-1:0]      sx;
    logic        [YW-1:0]      sy;
    logic        [AW-1:0]      rd_addr, wr_addr;
    logic                      wr_en;

    assign s1_query = r_s1_vld && (r_s1_kind == KIND_QUERY);

    // every query in flight owns a result FIFO slot
    assign reserve = {1'b0, i_out_count} + (CNT_W+1)'(s1_query)
                   + (CNT_W+1)'(r_s2_vld) + (CNT_W+1)'(r_s3_vld);
    assign o_mid_pop = !i_mid_empty && (32'(reserve) < OUT_DEPTH);

    always_comb begin
        cx_f  = SUM_W'(i_cfg.width[DIM_W-1:1]) << FRAC_BITS;
        cy_f  = SUM_W'(i_cfg.height[DIM_W-1:1]) << FRAC_BITS;
        lim_x = (SUM_W'(i_cfg.width) - SUM_W'(1)) << FRAC_BITS;
        lim_y = (SUM_W'(i_cfg.height) - SUM_W'(1)) << FRAC_BITS;

        rx = SUM_W'(r_p_xc) - SUM_W'(r_p_ys) + cx_f;
        ry = SUM_W'(r_p_xs) + SUM_W'(r_p_yc) + cy_f;

        outside = rx[SUM_W-1] || ry[SUM_W-1] || (rx > lim_x) || (ry > lim_y);
        sx      = rx[FRAC_BITS +: XW];
        sy      = ry[FRAC_BITS +: YW];
        rd_addr = outside ? '0 : AW'(sy) * ROW_STRIDE + AW'(sx);

        wr_addr = AW'(r_s1_y) * ROW_STRIDE + AW'(r_s1_x);
        wr_en   = r_s1_vld && (r_s1_kind == KIND_LOAD) && r_s1_ld_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= o_mid_pop;
            r_s2_vld <= s1_query;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind  <= i_mid_item.kind;
        r_s1_ld_ok <= i_mid_item.ld_ok;
        r_s1_x     <= i_mid_item.pos_x;
        r_s1_y     <= i_mid_item.pos_y;
        r_s1_pix   <= i_mid_item.pixel;
        r_p_xc     <= i_mid_item.dx * i_cfg.cos_v;
        r_p_ys     <= i_mid_item.dy * i_cfg.sin_v;
        r_p_xs     <= i_mid_item.dx * i_cfg.sin_v;
        r_p_yc     <= i_mid_item.dy * i_cfg.cos_v;
        r_s2_out   <= outside;
        r_s2_addr  <= rd_addr;
        r_s3_out   <= r_s2_out;
    end

    // a load writes at the same edge an older query reads, so program order holds
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_s1_pix;
        end
        if (r_s2_vld) begin
            r_rd <= r_mem[r_s2_addr];
        end
    end

    assign o_res_vld     = r_s3_vld;
    assign o_res.pixel   = r_s3_out ? i_cfg.fill : r_rd;
    assign o_res.outside = r_s3_out;

endmodule

[hw/rtl/image_rotate_nearest_core.sv]
// A push passes the front register, item queue and back-end stages to the result queue.
// One transaction per cycle unless full; the source store has one write and one read port.
// Load transactions produce no result; each query produces exactly one.
// Reset (synchronous, active low) empties all queues and pipeline stages and restores
// register defaults; the source store is not cleared and holds no meaning until written.
// Top level: APB register file, front end, item queue, back end and result queue.
`timescale 1ns / 1ps

module image_rotate_nearest_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_kind,
    input  logic [irn_pkg::POS_W-1:0]     i_pos_x,
    input  logic [irn_pkg::POS_W-1:0]     i_pos_y,
    input  logic [irn_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          empty,
    input  logic                          pop,
    output logic [irn_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_outside,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irn_pkg::PADDR_W-1:0]   paddr,
    input  logic [irn_pkg::PDATA_W-1:0]   pwdata,
    output logic [irn_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import irn_pkg::*;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    logic        [DIM_W-1:0]  r_width, r_height;
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic        [PIX_W-1:0]  r_fill;
    logic        [2:0]        reg_idx;
    logic                     wr_en;
    t_cfg                     cfg;

    logic    mid_full, mid_empty, mid_push, mid_pop;
    t_item   mid_in, mid_out;
    logic    res_vld;
    t_result res, res_head;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(256);
            r_height <= DIM_W'(256);
            r_cos    <= TRIG_W'(16384);
            r_sin    <= '0;
            r_fill   <= PIX_W'(24'hFF00FF);
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_COS:    r_cos    <= pwdata[TRIG_W-1:0];
                REG_SIN:    r_sin    <= pwdata[TRIG_W-1:0];
                REG_FILL:   r_fill   <= pwdata[PIX_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = PDATA_W'(r_width);
            REG_HEIGHT: prdata = PDATA_W'(r_height);
            REG_COS:    prdata = PDATA_W'($unsigned(r_cos));
            REG_SIN:    prdata = PDATA_W'($unsigned(r_sin));
            REG_FILL:   prdata = PDATA_W'(r_fill);
            default:    prdata = '0;
        endcase
    end

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        if (r_width == '0) begin
            cfg.width = DIM_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            cfg.width = DIM_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == '0) begin
            cfg.height = DIM_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            cfg.height = DIM_W'(MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
        cfg.cos_v = r_cos;
        cfg.sin_v = r_sin;
        cfg.fill  = r_fill;
    end

    // ---------------- datapath ----------------
    irn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_kind     (i_kind),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pixel_in (i_pixel_in),
        .i_cfg      (cfg),
        .i_mid_full (mid_full),
        .o_mid_push (mid_push),
        .o_mid_item (mid_in)
    );

    irn_fifo #(
        .WIDTH (($bits(t_item))),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_count ()
    );

    irn_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_out_count (out_count),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    irn_fifo #(
        .WIDTH (($bits(t_result))),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_full  (),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_pixel_out = res_head.pixel;
    assign o_outside   = res_head.outside;

endmodule

[hw/rtl/irn_checker.sv]
// Port-level checker for image_rotate_nearest_core, attached with a bind.
// Depends on irn_pkg for field widths.
`timescale 1ns / 1ps

module irn_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        i_kind,
    input logic                        empty,
    input logic                        pop,
    input logic [irn_pkg::PIX_W-1:0]   o_pixel_out,
    input logic                        o_outside,
    input logic                        pready
);

    import irn_pkg::*;

    // queries accepted and not yet popped
    logic [5:0] r_pending;
    logic       q_in, q_out;

    assign q_in  = push && !full && (i_kind == KIND_QUERY);
    assign q_out = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 6'(q_in) - 6'(q_out);
        end
    end

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_result_has_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pending != 6'd0))
        else $error("result shown without an outstanding query");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_out) && $stable(o_outside)))
        else $error("waiting result changed before it was popped");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind image_rotate_nearest_core irn_checker u_irn_checker (.*);
